[design/pls_pkg.sv]
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types, codes and sizes of the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_END   = 3'd1,
        REQ_INS_POS   = 3'd2,
        REQ_DEL_FRONT = 3'd3,
        REQ_DEL_END   = 3'd4,
        REQ_DEL_POS   = 3'd5,
        REQ_PEEK      = 3'd6
    } req_code_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]               req_type;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] head_value;
        logic [4:0]               entry_count;
        logic                     is_empty;
    } rsp_t;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic [CMP_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

[design/pls_cell.sv]
// ----------------------------------------------------------------------------
// pls_cell
// One list slot: holds an entry and shifts with its neighbours on edits.
// ----------------------------------------------------------------------------
module pls_cell (
    input  logic                              clk,
    input  pls_pkg::cell_ctl_t                ctl,
    input  logic [pls_pkg::CMP_W-1:0]         idx,
    input  logic signed [pls_pkg::DATA_W-1:0] left,
    input  logic signed [pls_pkg::DATA_W-1:0] right,
    output logic signed [pls_pkg::DATA_W-1:0] q,
    output logic signed [pls_pkg::DATA_W-1:0] d
);

    logic signed [pls_pkg::DATA_W-1:0] data_reg;
    logic signed [pls_pkg::DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (idx > ctl.pos)
                data_next = left;        // move back by one
            else if (idx == ctl.pos)
                data_next = ctl.value;
        end
        else if (ctl.del)
        begin
            if (idx >= ctl.pos)
                data_next = right;       // move forward by one
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;
    assign d = data_next;

endmodule

[design/pls_ctrl.sv]
// ----------------------------------------------------------------------------
// pls_ctrl
// Command decode: bounds checks, status and the edit sent to the cells.
// ----------------------------------------------------------------------------
module pls_ctrl (
    input  logic                     accept,
    input  pls_pkg::req_t            req,
    input  logic [pls_pkg::CNT_W-1:0] count,
    output pls_pkg::cell_ctl_t       ctl,
    output pls_pkg::status_t         status,
    output logic [pls_pkg::CNT_W-1:0] count_next
);

    logic [pls_pkg::CMP_W-1:0] pos_ext;
    logic [pls_pkg::CMP_W-1:0] cnt_ext;
    logic                      empty;
    logic                      full;
    logic                      ins;
    logic                      del;
    logic [pls_pkg::CMP_W-1:0] pos;

    assign pos_ext = pls_pkg::CMP_W'(req.position);
    assign cnt_ext = pls_pkg::CMP_W'(count);
    assign empty   = (count == '0);
    assign full    = (cnt_ext >= pls_pkg::CMP_W'(pls_pkg::CAPACITY));

    always_comb
    begin
        ins    = 1'b0;
        del    = 1'b0;
        pos    = '0;
        status = pls_pkg::ST_OK;
        unique case (pls_pkg::req_code_t'(req.req_type)) inside
            pls_pkg::REQ_INS_FRONT, pls_pkg::REQ_INS_END, pls_pkg::REQ_INS_POS:
            begin
                if (req.req_type == pls_pkg::REQ_INS_END)
                    pos = cnt_ext;
                else if (req.req_type == pls_pkg::REQ_INS_POS)
                    pos = pos_ext;
                if (pos > cnt_ext)
                    status = pls_pkg::ST_BOUNDS;
                else if (full)
                    status = pls_pkg::ST_FULL;
                else
                    ins = 1'b1;
            end
            pls_pkg::REQ_DEL_FRONT, pls_pkg::REQ_DEL_END, pls_pkg::REQ_DEL_POS:
            begin
                if (req.req_type == pls_pkg::REQ_DEL_END)
                    pos = cnt_ext - 1'b1;
                else if (req.req_type == pls_pkg::REQ_DEL_POS)
                    pos = pos_ext;
                if (empty)
                    status = pls_pkg::ST_EMPTY;
                else if (pos >= cnt_ext)
                    status = pls_pkg::ST_BOUNDS;
                else
                    del = 1'b1;
            end
            default:
            begin
                // peek, and the unused code acts as peek
                if (empty)
                    status = pls_pkg::ST_EMPTY;
            end
        endcase
    end

    assign ctl.ins   = ins & accept;
    assign ctl.del   = del & accept;
    assign ctl.pos   = pos;
    assign ctl.value = req.value;

    always_comb
    begin
        count_next = count;
        if (ctl.ins)
            count_next = count + 1'b1;
        else if (ctl.del)
            count_next = count - 1'b1;
    end

endmodule

[design/positional_list_store.sv]
// ----------------------------------------------------------------------------
// positional_list_store
// Bounded ordered list of signed 32-bit values held in a row of shift cells.
// ----------------------------------------------------------------------------
//
//  channel   ports              transfer
//  command   start, busy, req   start high while busy low
//  result    done, rsp          done high for one cycle, always taken
//
//  One command is taken every cycle; its result appears on rsp with done
//  in the following cycle. The figure is set by the cell row: every cell
//  loads its new entry from itself, a neighbour or the command on the
//  same edge, so an insert or delete anywhere in the list completes at once.
//  busy therefore stays low. Reset clears the count and the result strobe;
//  entry contents stay undefined until written and are never shown. The
//  receiver cannot stall the result.
//
module positional_list_store (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  pls_pkg::req_t  req,
    output logic           busy,
    output logic           done,
    output pls_pkg::rsp_t  rsp
);

    localparam int N = pls_pkg::CAPACITY;

    logic                              accept;
    pls_pkg::cell_ctl_t                ctl;
    pls_pkg::status_t                  status;
    logic [pls_pkg::CNT_W-1:0]         count_reg;
    logic [pls_pkg::CNT_W-1:0]         count_next;
    logic signed [pls_pkg::DATA_W-1:0] cell_q [N];
    logic signed [pls_pkg::DATA_W-1:0] cell_d [N];
    logic                              done_reg;
    pls_pkg::rsp_t                     rsp_reg;
    pls_pkg::rsp_t                     rsp_next;

    // The row finishes any edit at once, so never hold off a command
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    pls_ctrl u_ctrl (
        .accept     (accept),
        .req        (req),
        .count      (count_reg),
        .ctl        (ctl),
        .status     (status),
        .count_next (count_next)
    );

    // Row of cells; each looks at its left and right neighbour
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic signed [pls_pkg::DATA_W-1:0] left;
        logic signed [pls_pkg::DATA_W-1:0] right;

        if (i == 0)
        begin : g_first
            assign left = ctl.value;
        end
        else
        begin : g_inner_l
            assign left = cell_q[i-1];
        end

        // The last slot pulls in its own value; it lands beyond the count
        if (i == N - 1)
        begin : g_last
            assign right = cell_q[i];
        end
        else
        begin : g_inner_r
            assign right = cell_q[i+1];
        end

        pls_cell u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .idx   (pls_pkg::CMP_W'(i)),
            .left  (left),
            .right (right),
            .q     (cell_q[i]),
            .d     (cell_d[i])
        );
    end

    // Build the result from the state as it stands after the command
    always_comb
    begin
        rsp_next.status      = status;
        rsp_next.entry_count = 5'(count_next);
        rsp_next.is_empty    = (count_next == '0);
        rsp_next.head_value  = (count_next == '0) ? -32'sd1 : cell_d[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Hold the payload only when a command is taken
    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pls_pkg::CNT_W'(N))
        else $error("count exceeds capacity");

    a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted command gave no result");

    a_empty_head : assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.is_empty) |-> (rsp.head_value == -32'sd1))
        else $error("empty list shows a head value");

    a_fail_keeps_count : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status != pls_pkg::ST_OK) |=> (count_reg == $past(count_reg)))
        else $error("failed command changed the count");

endmodule
